/* hdl/bch_pkg.sv */
// package: shared widths, payload types, codes and field arithmetic for the bch codec
package bch_pkg;

  localparam int WORD_W = 63;
  localparam int ELEM_W = 6;
  localparam int FP_W   = 7;
  localparam int MAX_T  = 8;
  localparam int NCELL  = 2 * MAX_T + 1;
  localparam int IDX_W  = 5;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] codeword;
    logic [WORD_W-1:0] message;
    logic [1:0]        status;
    logic [3:0]        errors_fixed;
  } out_t;

  localparam logic       KIND_ENCODE = 1'b0;
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FAIL = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  localparam logic [2:0] REG_N = 3'd0;
  localparam logic [2:0] REG_K = 3'd1;
  localparam logic [2:0] REG_G = 3'd2;
  localparam logic [2:0] REG_F = 3'd3;
  localparam logic [2:0] REG_T = 3'd4;

  // cell operations
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_PREP  = 3'd1;
  localparam logic [2:0] OP_SYN   = 3'd2;
  localparam logic [2:0] OP_SHIFT = 3'd3;
  localparam logic [2:0] OP_MAC   = 3'd4;
  localparam logic [2:0] OP_UPD   = 3'd5;
  localparam logic [2:0] OP_QINIT = 3'd6;
  localparam logic [2:0] OP_CHIEN = 3'd7;

  typedef struct packed {
    logic [2:0]       op;
    logic [FP_W-1:0]  fp;
    logic [2:0]       fdeg;
    elem_t            beta;
    logic             bitv;
    elem_t            syn_in;
    elem_t            d;
    elem_t            inv;
    logic             upd;
    logic [IDX_W-1:0] lcur;
    logic [IDX_W-1:0] slen;
  } cell_ctrl_t;

  function automatic logic [2:0] field_deg(input logic [FP_W-1:0] fp);
    logic [2:0] dg;
    dg = 3'd0;
    for (int i = 0; i < FP_W; i++) begin
      if (fp[i]) dg = 3'(i);
    end
    return dg;
  endfunction

  // multiply by x, reduced
  function automatic elem_t gf_xtime(input elem_t p, input logic [FP_W-1:0] fp,
                                     input logic [2:0] fdeg);
    logic [FP_W-1:0] v;
    v = {p, 1'b0};
    if (v[fdeg]) v = v ^ fp;
    if (fdeg == 3'd0) v = '0;
    return v[ELEM_W-1:0];
  endfunction

  function automatic elem_t gf_mul(input elem_t a, input elem_t b,
                                   input logic [FP_W-1:0] fp, input logic [2:0] fdeg);
    elem_t p;
    p = '0;
    for (int i = ELEM_W - 1; i >= 0; i--) begin
      p = gf_xtime(p, fp, fdeg) ^ (b[i] ? a : elem_t'(0));
    end
    if (fdeg == 3'd0) p = '0;
    return p;
  endfunction

endpackage

/* hdl/bch_cell.sv */
// one cell of the decoder chain: power, syndrome, locator and chien terms of one index
module bch_cell import bch_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  elem_t            pw_prev,
  input  elem_t            sr_prev,
  input  elem_t            lam_prev,
  input  elem_t            tt_prev,
  output elem_t            pw,
  output elem_t            sr,
  output elem_t            lam,
  output elem_t            tt,
  output elem_t            syn,
  output elem_t            prod,
  output elem_t            q
);

  elem_t pw_r, sr_r, lam_r, tt_r, syn_r, prod_r, q_r;
  elem_t pw_nxt, sr_nxt, lam_nxt, tt_nxt, syn_nxt, prod_nxt, q_nxt;
  elem_t red1;
  logic  in_locator;
  logic  in_round;

  assign red1       = (ctrl.fdeg != 3'd0) ? elem_t'(1) : elem_t'(0);
  assign in_locator = (idx <= ctrl.lcur);
  assign in_round   = (idx <= ctrl.slen);

  always_comb begin
    pw_nxt   = pw_r;
    sr_nxt   = sr_r;
    lam_nxt  = lam_r;
    tt_nxt   = tt_r;
    syn_nxt  = syn_r;
    prod_nxt = prod_r;
    q_nxt    = q_r;
    case (ctrl.op)
      OP_PREP: begin
        pw_nxt  = (idx == '0) ? red1 : gf_mul(pw_prev, ctrl.beta, ctrl.fp, ctrl.fdeg);
        lam_nxt = (idx == '0) ? red1 : elem_t'(0);
        tt_nxt  = (idx == IDX_W'(1)) ? red1 : elem_t'(0);
        sr_nxt  = '0;
        syn_nxt = '0;
      end
      OP_SYN: begin
        syn_nxt = gf_mul(syn_r, pw_r, ctrl.fp, ctrl.fdeg)
                  ^ {{(ELEM_W-1){1'b0}}, ctrl.bitv & (ctrl.fdeg != 3'd0)};
      end
      OP_SHIFT: begin
        sr_nxt = (idx == '0) ? ctrl.syn_in : sr_prev;
      end
      OP_MAC: begin
        prod_nxt = in_locator ? gf_mul(lam_r, sr_r, ctrl.fp, ctrl.fdeg) : elem_t'(0);
      end
      OP_UPD: begin
        if (in_round) begin
          lam_nxt = lam_r ^ gf_mul(ctrl.d, tt_r, ctrl.fp, ctrl.fdeg);
          if (idx == '0) begin
            tt_nxt = '0;
          end else if (ctrl.upd) begin
            tt_nxt = gf_mul(ctrl.inv, lam_prev, ctrl.fp, ctrl.fdeg);
          end else begin
            tt_nxt = tt_prev;
          end
        end
      end
      OP_QINIT: begin
        q_nxt = gf_mul(lam_r, pw_r, ctrl.fp, ctrl.fdeg);
      end
      OP_CHIEN: begin
        if (idx != '0) q_nxt = gf_mul(q_r, pw_r, ctrl.fp, ctrl.fdeg);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pw_r   <= pw_nxt;
    sr_r   <= sr_nxt;
    lam_r  <= lam_nxt;
    tt_r   <= tt_nxt;
    syn_r  <= syn_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
  end

  assign pw   = pw_r;
  assign sr   = sr_r;
  assign lam  = lam_r;
  assign tt   = tt_r;
  assign syn  = syn_r;
  assign prod = prod_r;
  assign q    = in_locator ? q_r : elem_t'(0);

endmodule

/* hdl/bch_codec_unit.sv */
// top level: binary bch encoder and decoder built on a chain of syndrome/locator cells
//
// one transaction at a time: a word is taken when start is high and busy is low, and its
// result shows on out_data for exactly one cycle with out_valid high; the receiver cannot
// stall it. a word that is too long is answered in the cycle after it is taken, without
// going busy. encode runs the bit-serial division (S_MOD), then S_MODEND finishes and the
// result strobe comes in the cycle after. decode takes the division, then, if the
// remainder is not zero, loads field powers into the cells (S_PREP), runs the syndrome
// evaluation (one remainder bit per cycle into every cell), then 2t berlekamp-massey
// rounds (t capped at MAX_T) of S_SHIFT, S_MAC, S_SUM, S_DEC and S_UPD, with S_INV
// before S_UPD in each round that needs an inverse (serial square-and-multiply), a
// locator check and a chien setup, a chien search of up to n positions, one position
// per cycle, and S_FIN before the result strobe. the user writes configuration through
// cfg_we/cfg_index/cfg_data only while busy is low; the block does not enforce it.
module bch_codec_unit import bch_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  // controller states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MOD    = 4'd1;
  localparam logic [3:0] S_MODEND = 4'd2;
  localparam logic [3:0] S_PREP   = 4'd3;
  localparam logic [3:0] S_SYN    = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_MAC    = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_DEC    = 4'd8;
  localparam logic [3:0] S_INV    = 4'd9;
  localparam logic [3:0] S_UPD    = 4'd10;
  localparam logic [3:0] S_CHECK  = 4'd11;
  localparam logic [3:0] S_QINIT  = 4'd12;
  localparam logic [3:0] S_CHIEN  = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  // configuration registers
  logic [5:0]        n_r, k_r;
  logic [WORD_W-1:0] g_r;
  logic [FP_W-1:0]   fp_r;
  logic [3:0]        t_r;

  logic [3:0]        state_r, state_nxt;
  logic              kind_r, kind_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] base_r, base_nxt;   // encode: shifted message
  logic [WORD_W-1:0] rem_r, rem_nxt;     // division remainder, then syndrome bit stream
  logic [WORD_W-1:0] gs_r, gs_nxt;       // generator aligned to the current bit
  logic [WORD_W-1:0] mask_r, mask_nxt;   // located error positions
  logic [5:0]        b_r, b_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [5:0]        hits_r, hits_nxt;
  logic [IDX_W-1:0]  l_r, l_nxt;
  logic [IDX_W-1:0]  lr_r, lr_nxt;       // locator degree
  elem_t             d_r, d_nxt;
  elem_t             inv_r, inv_nxt;
  elem_t             sq_r, sq_nxt;
  logic [2:0]        icnt_r, icnt_nxt;
  logic              upd_r, upd_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  // derived values
  logic [2:0]        fdeg;
  elem_t             red1, beta;
  logic [3:0]        t_eff;
  logic [IDX_W-1:0]  s_len;
  logic [5:0]        sh, dg;
  logic [63:0]       lowk, lown;
  logic              long_k, long_n;
  elem_t             dsum, qsum;
  cell_ctrl_t        ctrl;

  elem_t pw_w[NCELL];
  elem_t sr_w[NCELL];
  elem_t lam_w[NCELL];
  elem_t tt_w[NCELL];
  elem_t syn_w[NCELL];
  elem_t prod_w[NCELL];
  elem_t q_w[NCELL];

  assign fdeg  = field_deg(fp_r);
  assign red1  = (fdeg != 3'd0) ? elem_t'(1) : elem_t'(0);
  assign beta  = gf_xtime(red1, fp_r, fdeg);
  assign t_eff = (t_r > 4'(MAX_T)) ? 4'(MAX_T) : t_r;
  assign s_len = {t_eff, 1'b0};
  assign sh    = (k_r <= n_r) ? (n_r - k_r) : 6'd0;
  assign lowk  = (64'd1 << k_r) - 64'd1;
  assign lown  = (64'd1 << n_r) - 64'd1;
  assign long_k = |(in_data.word & ~lowk[WORD_W-1:0]);
  assign long_n = |(in_data.word & ~lown[WORD_W-1:0]);

  // degree of the generator
  always_comb begin
    dg = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (g_r[i]) dg = 6'(i);
    end
  end

  // xor trees over the registered cell outputs
  always_comb begin
    dsum = '0;
    qsum = '0;
    for (int i = 0; i < NCELL; i++) begin
      dsum = dsum ^ prod_w[i];
      qsum = qsum ^ q_w[i];
    end
  end

  // the cell chain
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    elem_t pw_p, sr_p, lam_p, tt_p;
    if (g == 0) begin : g_first
      assign pw_p  = '0;
      assign sr_p  = '0;
      assign lam_p = '0;
      assign tt_p  = '0;
    end else begin : g_rest
      assign pw_p  = pw_w[g-1];
      assign sr_p  = sr_w[g-1];
      assign lam_p = lam_w[g-1];
      assign tt_p  = tt_w[g-1];
    end
    bch_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(g)),
      .ctrl     (ctrl),
      .pw_prev  (pw_p),
      .sr_prev  (sr_p),
      .lam_prev (lam_p),
      .tt_prev  (tt_p),
      .pw       (pw_w[g]),
      .sr       (sr_w[g]),
      .lam      (lam_w[g]),
      .tt       (tt_w[g]),
      .syn      (syn_w[g]),
      .prod     (prod_w[g]),
      .q        (q_w[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    rem_nxt       = rem_r;
    gs_nxt        = gs_r;
    mask_nxt      = mask_r;
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    hits_nxt      = hits_r;
    l_nxt         = l_r;
    lr_nxt        = lr_r;
    d_nxt         = d_r;
    inv_nxt       = inv_r;
    sq_nxt        = sq_r;
    icnt_nxt      = icnt_r;
    upd_nxt       = upd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    ctrl.op     = OP_HOLD;
    ctrl.fp     = fp_r;
    ctrl.fdeg   = fdeg;
    ctrl.beta   = beta;
    ctrl.bitv   = rem_r[WORD_W-1];
    ctrl.syn_in = syn_w[l_r];
    ctrl.d      = d_r;
    ctrl.inv    = inv_r;
    ctrl.upd    = upd_r;
    ctrl.lcur   = lr_r;
    ctrl.slen   = s_len;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_data.kind;
          word_nxt = in_data.word;
          gs_nxt   = g_r << (6'd62 - dg);
          b_nxt    = 6'd62;
          if (in_data.kind == KIND_ENCODE) begin
            if (long_k) begin
              out_nxt       = '{in_data.word, in_data.word, STATUS_LONG, 4'd0};
              out_valid_nxt = 1'b1;
            end else begin
              rem_nxt   = in_data.word << sh;
              base_nxt  = in_data.word << sh;
              state_nxt = S_MOD;
            end
          end else begin
            if (long_n) begin
              out_nxt       = '{in_data.word, {WORD_W{1'b0}}, STATUS_LONG, 4'd0};
              out_valid_nxt = 1'b1;
            end else begin
              rem_nxt   = in_data.word;
              state_nxt = S_MOD;
            end
          end
        end
      end
      // long division, one dividend bit per cycle from the top
      S_MOD: begin
        if (g_r == '0) begin
          state_nxt = S_MODEND;
        end else begin
          if (rem_r[b_r]) rem_nxt = rem_r ^ gs_r;
          gs_nxt = gs_r >> 1;
          if (b_r == dg) begin
            state_nxt = S_MODEND;
          end else begin
            b_nxt = b_r - 6'd1;
          end
        end
      end
      S_MODEND: begin
        if (kind_r == KIND_ENCODE) begin
          out_nxt       = '{base_r ^ rem_r, word_r, STATUS_OK, 4'd0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (rem_r == '0) begin
          out_nxt       = '{word_r, word_r >> sh, STATUS_OK, 4'd0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_PREP;
        end
      end
      // powers of beta ripple down the chain; locator and syndromes cleared
      S_PREP: begin
        ctrl.op = OP_PREP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(NCELL - 1)) begin
          cnt_nxt   = '0;
          lr_nxt    = '0;
          state_nxt = S_SYN;
        end
      end
      // horner evaluation in every cell, remainder bits fed msb first
      S_SYN: begin
        ctrl.op = OP_SYN;
        rem_nxt = rem_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(WORD_W - 1)) begin
          l_nxt     = IDX_W'(1);
          state_nxt = (s_len == '0) ? S_CHECK : S_SHIFT;
        end
      end
      // berlekamp-massey round: bring syndrome l in, discrepancy, update
      S_SHIFT: begin
        ctrl.op   = OP_SHIFT;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        ctrl.op   = OP_MAC;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        d_nxt     = dsum;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        upd_nxt = (d_r != '0) && ({lr_r, 1'b0} < {1'b0, l_r});
        inv_nxt = red1;
        sq_nxt  = gf_mul(d_r, d_r, fp_r, fdeg);
        icnt_nxt = 3'd1;
        if ((d_r != '0) && ({lr_r, 1'b0} < {1'b0, l_r}) && (fdeg > 3'd1)) begin
          state_nxt = S_INV;
        end else begin
          state_nxt = S_UPD;
        end
      end
      // d^(2^m-2) by square and multiply
      S_INV: begin
        inv_nxt = gf_mul(inv_r, sq_r, fp_r, fdeg);
        sq_nxt  = gf_mul(sq_r, sq_r, fp_r, fdeg);
        if (icnt_r == (fdeg - 3'd1)) begin
          state_nxt = S_UPD;
        end else begin
          icnt_nxt = icnt_r + 3'd1;
        end
      end
      S_UPD: begin
        ctrl.op = OP_UPD;
        if (upd_r) lr_nxt = l_r - lr_r;
        if (l_r == s_len) begin
          state_nxt = S_CHECK;
        end else begin
          l_nxt     = l_r + IDX_W'(1);
          state_nxt = S_SHIFT;
        end
      end
      S_CHECK: begin
        mask_nxt = '0;
        hits_nxt = '0;
        pos_nxt  = n_r - 6'd1;
        if (lr_r > {1'b0, t_eff}) begin
          out_nxt       = '{word_r, {WORD_W{1'b0}}, STATUS_FAIL, 4'd0};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_QINIT;
        end
      end
      S_QINIT: begin
        ctrl.op   = OP_QINIT;
        state_nxt = (n_r == '0) ? S_FIN : S_CHIEN;
      end
      // chien search, positions from the top down
      S_CHIEN: begin
        ctrl.op = OP_CHIEN;
        if (qsum == '0) begin
          mask_nxt[pos_r] = 1'b1;
          hits_nxt        = hits_r + 6'd1;
        end
        if (((qsum == '0) && ((hits_r + 6'd1) == {1'b0, lr_r})) || (pos_r == '0)) begin
          state_nxt = S_FIN;
        end else begin
          pos_nxt = pos_r - 6'd1;
        end
      end
      S_FIN: begin
        if (hits_r == {1'b0, lr_r}) begin
          out_nxt = '{word_r ^ mask_r, (word_r ^ mask_r) >> sh, STATUS_OK, lr_r[3:0]};
        end else begin
          out_nxt = '{word_r, {WORD_W{1'b0}}, STATUS_FAIL, 4'd0};
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= 6'd15;
      k_r         <= 6'd7;
      g_r         <= WORD_W'(465);
      fp_r        <= FP_W'(19);
      t_r         <= 4'd2;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_N:   n_r  <= cfg_data[5:0];
          REG_K:   k_r  <= cfg_data[5:0];
          REG_G:   g_r  <= cfg_data;
          REG_F:   fp_r <= cfg_data[FP_W-1:0];
          REG_T:   t_r  <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    word_r <= word_nxt;
    base_r <= base_nxt;
    rem_r  <= rem_nxt;
    gs_r   <= gs_nxt;
    mask_r <= mask_nxt;
    b_r    <= b_nxt;
    cnt_r  <= cnt_nxt;
    pos_r  <= pos_nxt;
    hits_r <= hits_nxt;
    l_r    <= l_nxt;
    lr_r   <= lr_nxt;
    d_r    <= d_nxt;
    inv_r  <= inv_nxt;
    sq_r   <= sq_nxt;
    icnt_r <= icnt_nxt;
    upd_r  <= upd_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sim/tb_bch_codec_unit.sv */
// testbench: bch codec unit checked against a bit-exact predictor over several code settings
module tb_bch_codec_unit import bch_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_t               in_data = '0;
  logic              out_valid;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = REG_N;
  logic [WORD_W-1:0] cfg_data = '0;

  // predictor copy of the code registers
  logic [5:0]  code_n = 6'd15;
  logic [5:0]  code_k = 6'd7;
  logic [62:0] code_gen = 63'd465;
  logic [6:0]  code_fpoly = 7'd19;
  logic [3:0]  code_t = 4'd2;

  in_t  pending_words[$];
  out_t awaited_results[$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  bit   steady = 1'b0;

  bch_codec_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- galois field and polynomial arithmetic ----------------
  function automatic int field_degree();
    int dg;
    dg = 0;
    for (int i = 0; i <= 6; i++) if (code_fpoly[i]) dg = i;
    return dg;
  endfunction

  // reduce modulo the field polynomial; degree zero collapses everything
  function automatic logic [63:0] fred(input logic [63:0] v);
    int dg;
    dg = field_degree();
    if (dg == 0) return 64'd0;
    for (int b = 13; b >= dg; b--)
      if (v[b]) v = v ^ (64'(code_fpoly) << (b - dg));
    return v;
  endfunction

  function automatic logic [63:0] fmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = 64'd0;
    a = fred(a);
    b = fred(b);
    for (int i = 0; i <= 6; i++) if (b[i]) p = p ^ (a << i);
    return fred(p);
  endfunction

  // d^(2^m-2) by square and multiply, whatever the polynomial
  function automatic logic [63:0] finv(input logic [63:0] a);
    logic [63:0] sq, r;
    int dg;
    sq = a;
    r = fred(64'd1);
    dg = field_degree();
    for (int i = 1; i < dg; i++) begin
      sq = fmul(sq, sq);
      r = fmul(r, sq);
    end
    return r;
  endfunction

  // remainder of a binary polynomial; a zero divisor leaves it as is
  function automatic logic [63:0] gen_remainder(input logic [63:0] w);
    int dg;
    logic [63:0] g;
    g = 64'(code_gen);
    if (g == 0) return w;
    dg = 0;
    for (int b = 0; b < 63; b++) if (g[b]) dg = b;
    for (int b = 62; b >= dg; b--) if (w[b]) w = w ^ (g << (b - dg));
    return {1'b0, w[62:0]};
  endfunction

  function automatic logic [63:0] horner_eval(input logic [63:0] r, input logic [63:0] x);
    logic [63:0] acc;
    acc = 64'd0;
    for (int b = 62; b >= 0; b--) acc = fred(fmul(acc, x) ^ 64'(r[b]));
    return acc;
  endfunction

  // ---------------- expected result of one transaction ----------------
  function automatic out_t predict_result(input in_t item);
    out_t res;
    logic [63:0] w, r, beta, msk, d, inv, sum;
    logic [63:0] pw[18], syn[18], lam[18], tt[18], nw[18], q[18];
    int n, k, sh, t, s, locdeg, cnt;
    w = {1'b0, item.word};
    n = code_n;
    k = code_k;
    sh = (k <= n) ? n - k : 0;
    res.codeword = item.word;
    res.message = '0;
    res.status = STATUS_OK;
    res.errors_fixed = '0;
    if (item.kind == KIND_ENCODE) begin
      res.message = item.word;
      if ((w >> k) != 0) begin
        res.status = STATUS_LONG;
        return res;
      end
      r = {1'b0, 63'(w << sh)};
      res.codeword = 63'(r ^ gen_remainder(r));
      return res;
    end
    if ((w >> n) != 0) begin
      res.status = STATUS_LONG;
      return res;
    end
    r = gen_remainder(w);
    if (r == 0) begin
      res.message = 63'(w >> sh);
      return res;
    end
    t = (code_t > MAX_T) ? MAX_T : code_t;
    s = 2 * t;
    beta = fred(64'd2);
    pw[0] = fred(64'd1);
    for (int j = 1; j < 18; j++) pw[j] = fmul(pw[j-1], beta);
    for (int j = 0; j < 18; j++) begin
      lam[j] = 0; tt[j] = 0; syn[j] = 0; nw[j] = 0; q[j] = 0;
    end
    for (int j = 0; j < s; j++) syn[j] = horner_eval(r, pw[j+1]);
    // berlekamp-massey
    locdeg = 0;
    lam[0] = fred(64'd1);
    tt[1] = fred(64'd1);
    for (int l = 1; l <= s; l++) begin
      d = 0;
      for (int i = 0; i <= locdeg && i < l; i++) d = d ^ fmul(lam[i], syn[l-1-i]);
      if (d != 0) begin
        for (int i = 0; i <= s; i++) nw[i] = lam[i] ^ fmul(d, tt[i]);
        if (2 * locdeg < l) begin
          inv = finv(d);
          for (int i = 0; i <= s; i++) tt[i] = fmul(inv, lam[i]);
          locdeg = l - locdeg;
        end
        for (int i = 0; i <= s; i++) lam[i] = nw[i];
      end
      for (int i = s; i > 0; i--) tt[i] = tt[i-1];
      tt[0] = 0;
    end
    if (locdeg > t) begin
      res.status = STATUS_FAIL;
      return res;
    end
    // chien search, stops at the expected number of roots
    msk = 0;
    cnt = 0;
    for (int j = 0; j <= locdeg; j++) q[j] = fmul(lam[j], pw[j]);
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j <= locdeg; j++) sum = sum ^ q[j];
      if (sum == 0) begin
        msk = msk | (64'd1 << (n - i - 1));
        cnt++;
        if (cnt == locdeg) break;
      end
      for (int j = 1; j <= locdeg; j++) q[j] = fmul(q[j], pw[j]);
    end
    if (cnt != locdeg) begin
      res.status = STATUS_FAIL;
      return res;
    end
    res.codeword = 63'(w ^ msk);
    res.message = 63'(res.codeword >> sh);
    res.errors_fixed = 4'(locdeg);
    return res;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    logic next_start;
    in_t  next_data;
    next_start = start;
    next_data = in_data;
    if (rst_n) begin
      // transaction accepted at this edge
      if (start && !busy) begin
        awaited_results = {awaited_results, predict_result(in_data)};
        void'(pending_words.pop_front());
        next_start = 1'b0;
      end
      if (!next_start && pending_words.size() > 0 &&
          (steady || $urandom_range(0, 99) >= 37)) begin
        next_start = 1'b1;
        next_data = pending_words[0];
      end
    end
    start <= next_start;
    in_data <= next_data;
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with no transaction outstanding");
        err_cnt++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_data.codeword !== exp_res.codeword) begin
          $error("codeword expected %h got %h", exp_res.codeword, out_data.codeword);
          err_cnt++;
        end
        if (out_data.message !== exp_res.message) begin
          $error("message expected %h got %h", exp_res.message, out_data.message);
          err_cnt++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status expected %0d got %0d", exp_res.status, out_data.status);
          err_cnt++;
        end
        if (out_data.errors_fixed !== exp_res.errors_fixed) begin
          $error("errors_fixed expected %0d got %0d", exp_res.errors_fixed,
                 out_data.errors_fixed);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  // block until every queued transaction has produced its result
  task automatic drain();
    while (pending_words.size() != 0 || start || awaited_results.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_N: code_n = val[5:0];
      REG_K: code_k = val[5:0];
      REG_G: code_gen = val;
      REG_F: code_fpoly = val[6:0];
      REG_T: code_t = val[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_code(input int n, input int k, input logic [62:0] g,
                          input int f, input int t);
    drain();
    write_reg(REG_N, 63'(n));
    write_reg(REG_K, 63'(k));
    write_reg(REG_G, g);
    write_reg(REG_F, 63'(f));
    write_reg(REG_T, 63'(t));
  endtask

  function automatic logic [62:0] rand_word();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic logic [62:0] low_mask(input int bits);
    return (bits >= 63) ? {63{1'b1}} : ((63'd1 << bits) - 63'd1);
  endfunction

  // a valid codeword for a message, via the encode path of the predictor
  function automatic logic [62:0] make_codeword(input logic [62:0] msg);
    in_t tmp;
    out_t res;
    tmp.kind = KIND_ENCODE;
    tmp.word = msg & low_mask(code_k);
    res = predict_result(tmp);
    return res.codeword;
  endfunction

  function automatic in_t make_item(input logic kind, input logic [62:0] w);
    in_t it;
    it.kind = kind;
    it.word = w;
    return it;
  endfunction

  // append one transaction to the driver queue
  task automatic enqueue(input logic kind, input logic [62:0] w);
    pending_words = {pending_words, make_item(kind, w)};
  endtask

  task automatic queue_random(input int count);
    int sel, nerr, tmax;
    logic [62:0] w;
    tmax = (code_t > MAX_T) ? MAX_T : code_t;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        enqueue(KIND_ENCODE, rand_word() & low_mask(code_k));
      end else if (sel < 80) begin
        // codeword with a few flipped bits, sometimes beyond t
        w = make_codeword(rand_word());
        nerr = $urandom_range(0, tmax + 1);
        for (int e = 0; e < nerr; e++) w[$urandom_range(0, code_n - 1)] ^= 1'b1;
        enqueue(~KIND_ENCODE, w & low_mask(code_n));
      end else if (sel < 90) begin
        enqueue(~KIND_ENCODE, rand_word() & low_mask(code_n));
      end else begin
        enqueue(1'($urandom_range(0, 1)), rand_word());
      end
    end
  endtask

  initial begin
    logic [62:0] cw;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset code (15,7,t=2)
    cw = make_codeword(63'h55);
    enqueue(KIND_ENCODE, 63'd0);
    enqueue(KIND_ENCODE, 63'd127);
    enqueue(KIND_ENCODE, 63'd128);
    enqueue(KIND_ENCODE, {63{1'b1}});
    enqueue(~KIND_ENCODE, 63'd0);
    enqueue(~KIND_ENCODE, cw);
    enqueue(~KIND_ENCODE, cw ^ 63'h1);
    enqueue(~KIND_ENCODE, cw ^ 63'h4000);
    enqueue(~KIND_ENCODE, cw ^ 63'h0101);
    enqueue(~KIND_ENCODE, cw ^ 63'h4001);
    enqueue(~KIND_ENCODE, cw ^ 63'h0491);
    enqueue(~KIND_ENCODE, cw ^ 63'h7f00);
    enqueue(~KIND_ENCODE, 63'h7fff);
    enqueue(~KIND_ENCODE, 63'h8000);
    enqueue(~KIND_ENCODE, {63{1'b1}});
    enqueue(~KIND_ENCODE, make_codeword(63'h7f));
    queue_random(100);

    // no idling on the sender side for this whole setting
    set_code(15, 5, 63'd1335, 19, 3);
    steady = 1'b1;
    queue_random(130);
    drain();
    steady = 1'b0;

    set_code(15, 11, 63'd19, 19, 1);
    queue_random(60);
    // sender holds off until all outstanding results are back
    drain();
    queue_random(60);

    set_code(7, 4, 63'd11, 11, 1);
    queue_random(120);
    set_code(31, 21, 63'd1897, 37, 2);
    queue_random(130);
    set_code(63, 57, 63'd67, 67, 1);
    queue_random(110);
    // top extremes of every register
    set_code(63, 63, {63{1'b1}}, 127, 15);
    queue_random(90);
    // bottom extremes: repetition code
    set_code(3, 1, 63'd7, 7, 1);
    queue_random(110);
    // k above n, zero generator, degree-zero field, no correction
    set_code(15, 20, 63'd0, 1, 0);
    queue_random(80);
    // t above the design of the generator, odd field polynomial
    set_code(15, 7, 63'd465, 25, 8);
    queue_random(110);

    drain();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
